// ===== design/pica_pkg.sv =====
// Shared types and constants for the PI controller with anti-windup.
package pica_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned ERR_W     = DATA_W + 1;
  localparam int unsigned PROD_W    = DATA_W + ERR_W;
  localparam int unsigned INTEG_W   = 32;
  localparam int unsigned SHIFT_P   = 2;
  localparam int unsigned SHIFT_I   = 4;
  localparam int unsigned SHIFT_OUT = 8;
  localparam int unsigned Y_W       = INTEG_W - SHIFT_OUT;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_OUT_MAX    = 2'd2,
    REG_OUT_MIN    = 2'd3
  } reg_idx_t;

  localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = 16'sh8000;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
  } cfg_t;

endpackage

// ===== design/pica_if.sv =====
// Valid/ready channel interfaces for controller samples and drive results.
interface pica_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pica_pkg::DATA_W-1:0]   reference;
  logic signed [pica_pkg::DATA_W-1:0]   measured;

  modport source (output valid, output reference, output measured, input ready);
  modport sink   (input valid, input reference, input measured, output ready);
endinterface

interface pica_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pica_pkg::DATA_W-1:0]   drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== design/pica_cfg_regs.sv =====
// Configuration register file: gains and output clamp limits.
module pica_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pica_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pica_pkg::DATA_W-1:0]         cfg_data,
  output pica_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain  <= '0;
      cfg.integ_gain <= '0;
      cfg.out_max    <= pica_pkg::OUT_MAX_RESET;
      cfg.out_min    <= pica_pkg::OUT_MIN_RESET;
    end else if (cfg_we) begin
      case (pica_pkg::reg_idx_t'(cfg_index))
        pica_pkg::REG_PROP_GAIN:  cfg.prop_gain  <= cfg_data;
        pica_pkg::REG_INTEG_GAIN: cfg.integ_gain <= cfg_data;
        pica_pkg::REG_OUT_MAX:    cfg.out_max    <= cfg_data;
        pica_pkg::REG_OUT_MIN:    cfg.out_min    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pica_datapath.sv =====
// One-pass PI arithmetic: error, gain products, output clamp, integrator update.
module pica_datapath (
  input  logic signed [pica_pkg::DATA_W-1:0]  reference,
  input  logic signed [pica_pkg::DATA_W-1:0]  measured,
  input  pica_pkg::cfg_t                      cfg,
  input  logic signed [pica_pkg::INTEG_W-1:0] integrator,
  output logic signed [pica_pkg::DATA_W-1:0]  drive,
  output logic signed [pica_pkg::INTEG_W-1:0] integrator_next
);

  logic signed [pica_pkg::ERR_W-1:0]    err;
  logic signed [pica_pkg::PROD_W-1:0]   p_prod;
  logic signed [pica_pkg::PROD_W-1:0]   i_prod;
  logic signed [pica_pkg::PROD_W-1:0]   p_shift;
  logic signed [pica_pkg::PROD_W-1:0]   i_shift;
  logic signed [pica_pkg::INTEG_W-1:0]  cand;
  logic signed [pica_pkg::INTEG_W-1:0]  sum;
  logic signed [pica_pkg::Y_W-1:0]      y;
  logic signed [pica_pkg::Y_W-1:0]      max_ext;
  logic signed [pica_pkg::Y_W-1:0]      min_ext;

  assign err = pica_pkg::ERR_W'(reference) - pica_pkg::ERR_W'(measured);

  assign p_prod = pica_pkg::PROD_W'($signed(cfg.prop_gain)) * pica_pkg::PROD_W'(err);
  assign i_prod = pica_pkg::PROD_W'($signed(cfg.integ_gain)) * pica_pkg::PROD_W'(err);

  assign p_shift = p_prod >>> pica_pkg::SHIFT_P;
  assign i_shift = i_prod >>> pica_pkg::SHIFT_I;

  // Cleared gain zeroes the candidate; it still passes through the hold tests.
  assign cand = (cfg.integ_gain != '0)
              ? pica_pkg::INTEG_W'(i_shift) + integrator
              : '0;

  assign sum = pica_pkg::INTEG_W'(p_shift) + cand;
  assign y   = sum[pica_pkg::INTEG_W-1:pica_pkg::SHIFT_OUT];

  assign max_ext = pica_pkg::Y_W'($signed(cfg.out_max));
  assign min_ext = pica_pkg::Y_W'($signed(cfg.out_min));

  always_comb begin
    logic signed [pica_pkg::Y_W-1:0]     y_clamp;
    logic signed [pica_pkg::INTEG_W-1:0] c;
    y_clamp = y;
    c       = cand;
    // Upper clamp first, then lower; each hold test compares with the old value.
    if (y_clamp > max_ext) begin
      y_clamp = max_ext;
      if (c > integrator) c = integrator;
    end
    if (y_clamp < min_ext) begin
      y_clamp = min_ext;
      if (c < integrator) c = integrator;
    end
    drive           = y_clamp[pica_pkg::DATA_W-1:0];
    integrator_next = c;
  end

endmodule

// ===== design/pi_controller_antiwindup.sv =====
// PI controller with conditional-integration anti-windup: each sample transaction
// (reference, measured) yields one drive transaction. A sample is registered on
// acceptance and the whole computation (two 16x17 gain products, integrator add,
// shift and clamp) runs from that input register into the output register once
// the output register is free or being drained; one sample is taken every cycle
// while the output is not stalled, and the integrator register, updated in that
// same pass, carries one sample's state to the next. The user must write gains
// and clamp limits through the cfg_we port only while the block is idle; the block itself does not enforce this.
module pi_controller_antiwindup (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pica_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pica_pkg::DATA_W-1:0]     cfg_data,
  pica_in_if.sink                         sample,
  pica_out_if.source                      result
);

  pica_pkg::cfg_t                      cfg;
  logic                                s1_valid;
  logic signed [pica_pkg::DATA_W-1:0]  s1_reference;
  logic signed [pica_pkg::DATA_W-1:0]  s1_measured;
  logic                                out_valid;
  logic signed [pica_pkg::DATA_W-1:0]  drive;
  logic signed [pica_pkg::DATA_W-1:0]  drive_next;
  logic signed [pica_pkg::INTEG_W-1:0] integrator;
  logic signed [pica_pkg::INTEG_W-1:0] integrator_next;
  logic                                advance;
  logic                                accept;

  pica_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pica_datapath u_dp (
    .reference       (s1_reference),
    .measured        (s1_measured),
    .cfg             (cfg),
    .integrator      (integrator),
    .drive           (drive_next),
    .integrator_next (integrator_next)
  );

  // Advance the held sample when the output register is free or being drained.
  assign advance      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || advance;
  assign accept       = sample.valid && sample.ready;

  assign result.valid = out_valid;
  assign result.drive = drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      integrator <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid  <= 1'b1;
        integrator <= integrator_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_reference <= sample.reference;
      s1_measured  <= sample.measured;
    end
    if (advance) begin
      drive <= drive_next;
    end
  end

  a_drive_above_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive >= cfg.out_min)
    else $error("drive below lower clamp");

  a_drive_below_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cfg.out_min <= cfg.out_max) |-> drive <= cfg.out_max)
    else $error("drive above upper clamp");

  a_integ_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(advance)) |-> $stable(integrator))
    else $error("integrator changed without a sample");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (s1_valid && out_valid && !result.ready))
    else $error("input stalled with room downstream");

endmodule
